>>> rtl/mme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

   // matrix dimension of the stores
   localparam int DIM = 16;

   // fixed field widths
   localparam int OP_W   = 2;
   localparam int POS_W  = 4;
   localparam int ELEM_W = 16;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int ACC_W  = 40;
   localparam int SIZE_W = 5;

   // derived from DIM
   localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CNT_W  = $clog2(DIM + 1);
   localparam int ADDR_W = $clog2(DIM * DIM);
   localparam int DEPTH  = DIM * DIM;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

   typedef struct packed {
      logic              we_a;
      logic              we_b;
      logic [ADDR_W-1:0] addr;
      logic [ELEM_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic clear;
      logic in_valid;
   } mac_ctl_type;

   typedef struct packed {
      logic busy;
   } mac_status_type;

endpackage

`default_nettype wire

>>> rtl/mme_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mme_req_if;
   logic                          valid;
   logic                          ready;
   logic [mme_pkg::OP_W-1:0]      op;
   logic [mme_pkg::POS_W-1:0]     row;
   logic [mme_pkg::POS_W-1:0]     col;
   logic signed [mme_pkg::ELEM_W-1:0] value;

   modport source (output valid, output op, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input op, input row, input col, input value,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/mme_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mme_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mme_pkg::POS_W-1:0]        result_row;
   logic [mme_pkg::POS_W-1:0]        result_col;
   logic signed [mme_pkg::ACC_W-1:0] product_value;

   modport source (output valid, output result_row, output result_col,
                   output product_value, input ready);
   modport sink   (input valid, input result_row, input result_col,
                   input product_value, output ready);
endinterface

`default_nettype wire

>>> rtl/mme_store.sv
`timescale 1ns / 1ps
`default_nettype none

// A and B element stores, one write port shared, one registered read port each
module mme_store (
   input  wire                                clock,
   input  wire mme_pkg::store_wr_type         wr,
   input  wire  [mme_pkg::ADDR_W-1:0]         rd_addr_a,
   input  wire  [mme_pkg::ADDR_W-1:0]         rd_addr_b,
   output logic signed [mme_pkg::ELEM_W-1:0]  rd_data_a,
   output logic signed [mme_pkg::ELEM_W-1:0]  rd_data_b
);

   logic [mme_pkg::ELEM_W-1:0] a_mem [mme_pkg::DEPTH];
   logic [mme_pkg::ELEM_W-1:0] b_mem [mme_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (wr.we_a) begin
         a_mem[wr.addr] <= wr.data;
      end
      rd_data_a <= a_mem[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr.we_b) begin
         b_mem[wr.addr] <= wr.data;
      end
      rd_data_b <= b_mem[rd_addr_b];
   end

endmodule

`default_nettype wire

>>> rtl/mme_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared multiply-accumulate: product register, then accumulator
module mme_mac (
   input  wire                               clock,
   input  wire                               reset,
   input  wire mme_pkg::mac_ctl_type         ctl,
   input  wire  signed [mme_pkg::ELEM_W-1:0] a,
   input  wire  signed [mme_pkg::ELEM_W-1:0] b,
   output mme_pkg::mac_status_type           status,
   output logic signed [mme_pkg::ACC_W-1:0]  acc
);

   logic signed [mme_pkg::PROD_W-1:0] prod_ff;
   logic signed [mme_pkg::PROD_W-1:0] prod_in;
   logic                              prod_v_ff;
   logic signed [mme_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mme_pkg::ACC_W-1:0]  acc_in;

   always_comb begin
      prod_in = a * b;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + {{(mme_pkg::ACC_W-mme_pkg::PROD_W){prod_ff[mme_pkg::PROD_W-1]}},
                            prod_ff};
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= ctl.in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.in_valid) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign status.busy = prod_v_ff;
   assign acc         = acc_ff;

endmodule

`default_nettype wire

>>> rtl/matrix_multiply_engine.sv
// Element writes: one request per cycle while no query runs, no result.
// Query: after accept, each of the n terms (n = active size) is issued through the shared MAC,
// then the store read, product and accumulate stages drain and the result is registered.
// Not ready while a query runs; a held result delays the answer and the next accept.
// A query outside the store skips the MAC and answers 0.
// Synchronous active-high reset clears control and sets size to 16; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_engine (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_wr_en,
   input  wire  [mme_pkg::SIZE_W-1:0]       csr_wr_data,
   mme_req_if.sink                          req_ch,
   mme_rsp_if.source                        rsp_ch
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [mme_pkg::SIZE_W-1:0]       size_ff;
   logic [mme_pkg::CNT_W-1:0]        n_active;
   logic [mme_pkg::CNT_W-1:0]        k_ff, k_in;
   logic [mme_pkg::POS_W-1:0]        row_ff, row_in;
   logic [mme_pkg::POS_W-1:0]        col_ff, col_in;
   logic                             issue_v_ff, issue_v_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mme_pkg::POS_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [mme_pkg::ACC_W-1:0] rsp_value_ff;
   logic                             load_rsp;

   logic                             req_take;
   logic                             req_inside;
   logic [mme_pkg::IDX_W-1:0]        k_idx;
   logic [mme_pkg::ADDR_W-1:0]       rd_addr_a, rd_addr_b;
   mme_pkg::store_wr_type            wr;
   mme_pkg::mac_ctl_type             mac_ctl;
   mme_pkg::mac_status_type          mac_status;
   logic signed [mme_pkg::ELEM_W-1:0] rd_data_a, rd_data_b;
   logic signed [mme_pkg::ACC_W-1:0] acc;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign req_inside   = (32'(req_ch.row) < 32'(mme_pkg::DIM)) &&
                         (32'(req_ch.col) < 32'(mme_pkg::DIM));

   // size 0 acts as 1, sizes above DIM clamp to DIM
   always_comb begin
      if (size_ff == '0) begin
         n_active = mme_pkg::CNT_W'(1);
      end else if (32'(size_ff) > 32'(mme_pkg::DIM)) begin
         n_active = mme_pkg::CNT_W'(mme_pkg::DIM);
      end else begin
         n_active = mme_pkg::CNT_W'(size_ff);
      end
   end

   assign k_idx     = k_ff[mme_pkg::IDX_W-1:0];
   assign rd_addr_a = mme_pkg::ADDR_W'(row_ff) * mme_pkg::ADDR_W'(mme_pkg::DIM)
                      + mme_pkg::ADDR_W'(k_idx);
   assign rd_addr_b = mme_pkg::ADDR_W'(k_idx) * mme_pkg::ADDR_W'(mme_pkg::DIM)
                      + mme_pkg::ADDR_W'(col_ff);

   always_comb begin
      wr.we_a = req_take && req_inside && (req_ch.op == mme_pkg::OP_WRITE_A);
      wr.we_b = req_take && req_inside && (req_ch.op == mme_pkg::OP_WRITE_B);
      wr.addr = mme_pkg::ADDR_W'(req_ch.row) * mme_pkg::ADDR_W'(mme_pkg::DIM)
                + mme_pkg::ADDR_W'(req_ch.col);
      wr.data = req_ch.value;
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      issue_v_in   = 1'b0;
      load_rsp     = 1'b0;
      mac_ctl.clear    = 1'b0;
      mac_ctl.in_valid = issue_v_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_ch.op == mme_pkg::OP_QUERY)) begin
               row_in        = req_ch.row;
               col_in        = req_ch.col;
               k_in          = '0;
               mac_ctl.clear = 1'b1;
               // outside the store: no products, answer 0
               state_in      = req_inside ? ST_RUN : ST_DRAIN;
            end
         end
         ST_RUN: begin
            issue_v_in = 1'b1;
            k_in       = k_ff + 1'b1;
            if (k_ff == n_active - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!issue_v_ff && !mac_status.busy && (!rsp_valid_ff || rsp_ch.ready)) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= mme_pkg::SIZE_RESET;
         issue_v_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         issue_v_ff   <= issue_v_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      if (load_rsp) begin
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
         rsp_value_ff <= acc;
      end
   end

   mme_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mme_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .a      (rd_data_a),
      .b      (rd_data_b),
      .status (mac_status),
      .acc    (acc)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_row    = rsp_row_ff;
   assign rsp_ch.result_col    = rsp_col_ff;
   assign rsp_ch.product_value = rsp_value_ff;

endmodule

`default_nettype wire

>>> rtl/mme_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mme_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_ready,
   input wire [mme_pkg::OP_W-1:0]          req_op,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [mme_pkg::POS_W-1:0]         rsp_result_row,
   input wire [mme_pkg::POS_W-1:0]         rsp_result_col,
   input wire [mme_pkg::ACC_W-1:0]         rsp_product_value
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_row)
         && $stable(rsp_result_col) && $stable(rsp_product_value))
      else $error("stalled response changed");

   // a query blocks further requests while it runs
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == mme_pkg::OP_QUERY) |=> !req_ready)
      else $error("request accepted during query");

   // writes and unused codes never raise a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op != mme_pkg::OP_QUERY) && !rsp_valid
         |=> !rsp_valid)
      else $error("response without query");

   // a new response only comes out of a running query
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised while idle");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_op            (req_ch.op),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_result_row    (rsp_ch.result_row),
   .rsp_result_col    (rsp_ch.result_col),
   .rsp_product_value (rsp_ch.product_value)
);

`default_nettype wire

>>> tb/matrix_multiply_engine_tb.sv
`timescale 1ns / 1ps

module matrix_multiply_engine_tb;

   localparam logic [mme_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [mme_pkg::POS_W-1:0] POS_LAST = mme_pkg::POS_W'(mme_pkg::DIM - 1);
   localparam logic signed [mme_pkg::ELEM_W-1:0] ELEM_MIN = 16'sh8000;
   localparam logic signed [mme_pkg::ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;

   typedef struct packed {
      logic [mme_pkg::POS_W-1:0]        row;
      logic [mme_pkg::POS_W-1:0]        col;
      logic signed [mme_pkg::ACC_W-1:0] value;
   } product_type;

   typedef enum {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_mode_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_wr_en;
   logic [mme_pkg::SIZE_W-1:0]  csr_wr_data;

   mme_req_if req_ch();
   mme_rsp_if rsp_ch();

   matrix_multiply_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // shadow copy of the element stores and the size register
   logic signed [mme_pkg::ELEM_W-1:0] a_elems [mme_pkg::DEPTH];
   logic signed [mme_pkg::ELEM_W-1:0] b_elems [mme_pkg::DEPTH];
   logic [mme_pkg::SIZE_W-1:0]        size_setting;

   product_type pending_products[$];
   int          error_count;
   int          burst_left;
   bit          hold_rsp;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int active_len();
      int n;
      n = int'(size_setting);
      if (n == 0) n = 1;
      if (n > mme_pkg::DIM) n = mme_pkg::DIM;
      return n;
   endfunction

   function automatic logic [mme_pkg::ADDR_W-1:0] elem_addr(
         input logic [mme_pkg::POS_W-1:0] r, input logic [mme_pkg::POS_W-1:0] c);
      return mme_pkg::ADDR_W'(r) * mme_pkg::ADDR_W'(mme_pkg::DIM) + mme_pkg::ADDR_W'(c);
   endfunction

   function automatic logic signed [mme_pkg::ACC_W-1:0] dot_product(
         input logic [mme_pkg::POS_W-1:0] row, input logic [mme_pkg::POS_W-1:0] col);
      longint acc;
      acc = 0;
      if (int'(row) < mme_pkg::DIM && int'(col) < mme_pkg::DIM) begin
         for (int k = 0; k < active_len(); k++) begin
            acc += longint'(a_elems[elem_addr(row, mme_pkg::POS_W'(k))])
                   * longint'(b_elems[elem_addr(mme_pkg::POS_W'(k), col)]);
         end
      end
      return acc[mme_pkg::ACC_W-1:0];
   endfunction

   function automatic logic signed [mme_pkg::ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 7))
         0:       return ELEM_MIN;
         1:       return ELEM_MAX;
         default: return mme_pkg::ELEM_W'($urandom());
      endcase
   endfunction

   function automatic logic [mme_pkg::POS_W-1:0] pick_pos();
      return mme_pkg::POS_W'($urandom_range(0, mme_pkg::DIM - 1));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // update the shadow stores, or queue the product a query should return
   task automatic absorb_request(input logic [mme_pkg::OP_W-1:0] op,
                                 input logic [mme_pkg::POS_W-1:0] row,
                                 input logic [mme_pkg::POS_W-1:0] col,
                                 input logic signed [mme_pkg::ELEM_W-1:0] value);
      product_type want;
      case (op)
         mme_pkg::OP_WRITE_A: begin
            if (int'(row) < mme_pkg::DIM && int'(col) < mme_pkg::DIM)
               a_elems[elem_addr(row, col)] = value;
         end
         mme_pkg::OP_WRITE_B: begin
            if (int'(row) < mme_pkg::DIM && int'(col) < mme_pkg::DIM)
               b_elems[elem_addr(row, col)] = value;
         end
         mme_pkg::OP_QUERY: begin
            want.row   = row;
            want.col   = col;
            want.value = dot_product(row, col);
            pending_products.push_back(want);
         end
         default: ;
      endcase
   endtask

   task automatic send_request(input logic [mme_pkg::OP_W-1:0] op,
                               input logic [mme_pkg::POS_W-1:0] row,
                               input logic [mme_pkg::POS_W-1:0] col,
                               input logic signed [mme_pkg::ELEM_W-1:0] value);
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.row   <= row;
      req_ch.col   <= col;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      absorb_request(op, row, col, value);
   endtask

   task automatic pause_requests(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   // send with bursty spacing
   task automatic issue(input logic [mme_pkg::OP_W-1:0] op,
                        input logic [mme_pkg::POS_W-1:0] row,
                        input logic [mme_pkg::POS_W-1:0] col,
                        input logic signed [mme_pkg::ELEM_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) pause_requests(gap);
      end
      burst_left--;
      send_request(op, row, col, value);
   endtask

   task automatic wait_drained();
      pause_requests(1);
      while (pending_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_size(input logic [mme_pkg::SIZE_W-1:0] n);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      size_setting = n;
   endtask

   // every element gets written before any query reads it
   task automatic test_fill_stores();
      logic signed [mme_pkg::ELEM_W-1:0] v;
      for (int r = 0; r < mme_pkg::DIM; r++) begin
         for (int c = 0; c < mme_pkg::DIM; c++) begin
            if (r == mme_pkg::DIM-1) v = ELEM_MIN;
            else if (r == 0)         v = ELEM_MAX;
            else                     v = pick_element();
            issue(mme_pkg::OP_WRITE_A, mme_pkg::POS_W'(r), mme_pkg::POS_W'(c), v);
            v = (c == 0 || c == mme_pkg::DIM-1) ? ELEM_MIN : pick_element();
            issue(mme_pkg::OP_WRITE_B, mme_pkg::POS_W'(r), mme_pkg::POS_W'(c), v);
         end
      end
   endtask

   task automatic test_directed_extremes();
      // reset size: largest positive and most negative sums
      issue(mme_pkg::OP_QUERY, POS_LAST, POS_LAST, 16'sd0);
      issue(mme_pkg::OP_QUERY, 4'd0, 4'd0, -16'sd1);
      issue(OP_UNUSED, 4'hf, 4'hf, -16'sd1);
      issue(mme_pkg::OP_QUERY, POS_LAST, 4'd0, 16'sd0);
      set_size(5'd1);
      send_request(mme_pkg::OP_WRITE_A, 4'd0, 4'd0, ELEM_MIN);
      send_request(mme_pkg::OP_WRITE_B, 4'd0, 4'd0, ELEM_MIN);
      send_request(mme_pkg::OP_QUERY, 4'd0, 4'd0, 16'sd0);
      send_request(mme_pkg::OP_WRITE_A, 4'd3, 4'd0, ELEM_MAX);
      send_request(mme_pkg::OP_WRITE_B, 4'd0, 4'd7, ELEM_MIN);
      send_request(mme_pkg::OP_QUERY, 4'd3, 4'd7, 16'sd0);
      issue(mme_pkg::OP_QUERY, POS_LAST, POS_LAST, 16'sd0);
      // size zero acts as one, sizes above DIM act as DIM
      set_size(5'd0);
      issue(mme_pkg::OP_QUERY, 4'd0, 4'd0, 16'sd0);
      issue(mme_pkg::OP_QUERY, 4'd3, 4'd7, 16'sd0);
      set_size(5'd31);
      issue(mme_pkg::OP_QUERY, POS_LAST, POS_LAST, 16'sd0);
      issue(mme_pkg::OP_QUERY, 4'd0, POS_LAST, 16'sd0);
      set_size(5'd2);
      issue(mme_pkg::OP_QUERY, 4'd5, 4'd9, 16'sd0);
   endtask

   task automatic run_traffic(input int count);
      int                        done_items;
      int                        nw;
      logic [mme_pkg::POS_W-1:0] r;
      logic [mme_pkg::POS_W-1:0] c;
      logic [mme_pkg::POS_W-1:0] k;
      done_items = 0;
      while (done_items < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
               // update some terms of one dot product, then read it back
               r  = pick_pos();
               c  = pick_pos();
               nw = $urandom_range(1, 4);
               repeat (nw) begin
                  k = mme_pkg::POS_W'($urandom_range(0, active_len()-1));
                  if ($urandom_range(0, 1) != 0)
                     issue(mme_pkg::OP_WRITE_A, r, k, pick_element());
                  else
                     issue(mme_pkg::OP_WRITE_B, k, c, pick_element());
               end
               issue(mme_pkg::OP_QUERY, r, c, mme_pkg::ELEM_W'($urandom()));
               done_items += nw + 1;
            end
            7, 8: begin
               issue(mme_pkg::OP_W'($urandom_range(mme_pkg::OP_WRITE_A, mme_pkg::OP_QUERY)),
                     pick_pos(), pick_pos(), pick_element());
               done_items++;
            end
            default: begin
               issue(OP_UNUSED, mme_pkg::POS_W'($urandom()), mme_pkg::POS_W'($urandom()),
                     mme_pkg::ELEM_W'($urandom()));
               done_items++;
            end
         endcase
      end
   endtask

   task automatic test_random_traffic();
      logic [mme_pkg::SIZE_W-1:0] n;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       n = 5'd31;
            1:       n = 5'd0;
            2:       n = 5'd1;
            3:       n = 5'd2;
            4:       n = 5'd16;
            5:       n = mme_pkg::SIZE_W'($urandom_range(3, 15));
            6:       n = mme_pkg::SIZE_W'($urandom_range(17, 30));
            default: n = mme_pkg::SIZE_W'($urandom_range(1, 16));
         endcase
         set_size(n);
         run_traffic(118);
      end
   endtask

   // results held back while queries keep coming
   task automatic test_backpressure();
      set_size(5'd16);
      hold_rsp = 1'b1;
      repeat (24)
         send_request(mme_pkg::OP_QUERY, pick_pos(), pick_pos(), mme_pkg::ELEM_W'($urandom()));
      pause_requests(1);
   endtask

   initial begin : rsp_ready_driver
      rx_mode_type mode;
      int          mode_left;
      int          phase;
      rsp_ch.ready = 1'b0;
      mode_left = 0;
      mode = RX_ALWAYS;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if (mode_left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
            phase = 0;
         end
         mode_left--;
         phase++;
         case (mode)
            RX_ALWAYS:   rsp_ch.ready <= 1'b1;
            RX_COIN:     rsp_ch.ready <= ($urandom_range(0, 1) != 0);
            RX_PERIODIC: rsp_ch.ready <= (phase % 7) < 3;
            default:     rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   initial begin : product_checker
      product_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_products.size() == 0) begin
               report_mismatch($sformatf("unexpected result row %0d col %0d",
                                         rsp_ch.result_row, rsp_ch.result_col));
            end else begin
               want = pending_products.pop_front();
               if (rsp_ch.result_row !== want.row)
                  report_mismatch($sformatf("result_row %0d, want %0d",
                                            rsp_ch.result_row, want.row));
               if (rsp_ch.result_col !== want.col)
                  report_mismatch($sformatf("result_col %0d, want %0d",
                                            rsp_ch.result_col, want.col));
               if (rsp_ch.product_value !== want.value)
                  report_mismatch($sformatf("product (%0d,%0d) = %0d, want %0d",
                                            want.row, want.col,
                                            rsp_ch.product_value, want.value));
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("matrix_multiply_engine_tb: done, errors");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_ch.valid = 1'b0;
      req_ch.op    = '0;
      req_ch.row   = '0;
      req_ch.col   = '0;
      req_ch.value = '0;
      error_count  = 0;
      burst_left   = 0;
      hold_rsp     = 1'b0;
      size_setting = mme_pkg::SIZE_RESET;
      a_elems      = '{default: '0};
      b_elems      = '{default: '0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fill_stores();
      test_directed_extremes();
      test_random_traffic();
      test_backpressure();
      wait_drained();

      if (pending_products.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_products.size()));
      if (error_count == 0)
         $display("matrix_multiply_engine_tb: done, clean");
      else
         $display("matrix_multiply_engine_tb: done, errors");
      $finish;
   end

endmodule
